// ===== sv/sni_pkg.sv =====
// types and fixed constants shared by the smooth normal interpolator
`timescale 1ns / 1ps

package sni_pkg;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_SHADE = 1'b1;

   localparam logic [1:0] CORNER_NONE = 2'd3;

   localparam logic [18:0] ONE_Q16 = 19'd65536;

   localparam int NORM_MSB   = 29;
   localparam int SQRT_STEPS = 31;
   localparam int DIV_STEPS  = 15;

   typedef struct packed {
      logic               func;
      logic [9:0]         tri_index;
      logic [1:0]         corner;
      logic [16:0]        weight_u;
      logic [16:0]        weight_v;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic signed [31:0] eye_x;
      logic signed [31:0] eye_y;
      logic signed [31:0] eye_z;
   } req_type;

   typedef struct packed {
      logic signed [15:0] norm_x;
      logic signed [15:0] norm_y;
      logic signed [15:0] norm_z;
      logic               index_error;
      logic               zero_blend;
   } rsp_type;

   typedef struct packed {
      logic               err;
      logic               zb;
      logic [2:0]         neg;
      logic signed [32:0] dx;
      logic signed [32:0] dy;
      logic signed [32:0] dz;
   } side_type;

endpackage

// ===== sv/sni_ram.sv =====
// generic single write port ram with registered read
`timescale 1ns / 1ps

module sni_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [0:DEPTH-1];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

// ===== sv/smooth_normal_interpolator.sv =====
// top level: vertex normal table with pipelined barycentric blend and normalise
//
// req channel (valid/ready): func 0 writes one corner normal into the table,
// func 1 shades a hit point of a triangle. A load gives no response; a shade
// gives exactly one rsp transfer. csr channel writes tri_count and is always
// ready; write it only while the block is idle.
// A shade passes stages a to h, the square root, the divider, stages j and k
// and the output register before rsp_valid rises. Throughput: one req transfer
// per cycle unless a held result stalls the pipeline; the blend, the 31 stage
// square root and the 15 stage per component divider are all fully pipelined.
// The table lives in three rams, one per corner, each read once per cycle while the pipeline advances.
// Reset clears tri_count and all valid bits; table contents stay undefined
// until loaded. When rsp_ready is low with a result waiting, the whole
// pipeline holds and req_ready drops; nothing is lost or repeated.
`timescale 1ns / 1ps

module smooth_normal_interpolator #(
   parameter int MAX_TRIANGLES = 1024
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  sni_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output sni_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_data
);

   localparam int ADDR_W = (MAX_TRIANGLES > 1) ? $clog2(MAX_TRIANGLES) : 1;
   localparam int SQ     = sni_pkg::SQRT_STEPS;
   localparam int DV     = sni_pkg::DIV_STEPS;

   function automatic logic signed [15:0] sat16(logic signed [31:0] x);
      logic signed [15:0] r;
      if (x > 32'sd32767) r = 16'sh7fff;
      else if (x < -32'sd32768) r = 16'sh8000;
      else r = x[15:0];
      return r;
   endfunction

   function automatic logic [5:0] lead_one(logic [35:0] x);
      logic [5:0] p;
      p = '0;
      for (int k = 0; k < 36; k++) begin
         if (x[k]) p = 6'(k);
      end
      return p;
   endfunction

   logic adv, accept, idx_in_range, load_en;
   logic [ADDR_W-1:0] addr;
   logic [47:0] wr_data;
   logic [47:0] rd_data [0:2];
   logic [10:0] tri_count_ff;

   logic out_vld_ff;
   sni_pkg::rsp_type out_data_ff;

   assign adv       = !out_vld_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;
   assign accept    = req_valid && adv;
   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_data_ff;

   assign idx_in_range = int'(req_data.tri_index) < MAX_TRIANGLES;
   assign addr    = ADDR_W'(req_data.tri_index);
   assign load_en = accept && (req_data.func == sni_pkg::FUNC_LOAD)
                    && (req_data.corner != sni_pkg::CORNER_NONE) && idx_in_range;
   assign wr_data = {sat16(req_data.vec_x), sat16(req_data.vec_y), sat16(req_data.vec_z)};

   always_ff @(posedge clock) begin
      if (reset) begin
         tri_count_ff <= '0;
      end else if (csr_valid) begin
         tri_count_ff <= csr_data;
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_ram
      sni_ram #(.WIDTH(48), .DEPTH(MAX_TRIANGLES)) u_ram (
         .clock   (clock),
         .wr_en   (load_en && (req_data.corner == 2'(c))),
         .wr_addr (addr),
         .wr_data (wr_data),
         .rd_en   (adv),
         .rd_addr (addr),
         .rd_data (rd_data[c])
      );
   end

   // stage a: request registered, table read in flight
   logic a_vld_ff, a_err_ff;
   logic signed [18:0] a_w_ff [0:2];
   logic signed [32:0] a_d_ff [0:2];
   logic a_err_in;

   assign a_err_in = !(({1'b0, req_data.tri_index} < tri_count_ff) && idx_in_range);

   // stage b: products
   logic b_vld_ff;
   logic signed [34:0] b_p_ff [0:2][0:2];
   sni_pkg::side_type b_side_ff, b_side_in;

   // stage c: blended sums
   logic c_vld_ff;
   logic signed [36:0] c_b_ff [0:2];
   sni_pkg::side_type c_side_ff;

   // stage d: magnitudes
   logic d_vld_ff;
   logic [35:0] d_mag_ff [0:2];
   sni_pkg::side_type d_side_ff, d_side_in;

   // stage e: largest magnitude
   logic e_vld_ff;
   logic [35:0] e_mag_ff [0:2];
   logic [35:0] e_m_ff, e_m_in;
   sni_pkg::side_type e_side_ff;

   // stage f: leading one
   logic f_vld_ff;
   logic [35:0] f_mag_ff [0:2];
   logic [5:0] f_pos_ff;
   sni_pkg::side_type f_side_ff;

   // stage g: group shift
   logic g_vld_ff;
   logic [29:0] g_mag_ff [0:2];
   logic [29:0] g_mag_in [0:2];
   sni_pkg::side_type g_side_ff;

   // stage h: squares
   logic h_vld_ff;
   logic [29:0] h_mag_ff [0:2];
   logic [59:0] h_sq_ff [0:2];
   sni_pkg::side_type h_side_ff;

   // square root pipeline
   logic sq_vld_ff [0:SQ];
   logic [61:0] sq_x_ff [0:SQ];
   logic [34:0] sq_rem_ff [0:SQ];
   logic [30:0] sq_root_ff [0:SQ];
   logic [29:0] sq_mag_ff [0:SQ][0:2];
   sni_pkg::side_type sq_side_ff [0:SQ];

   // divider pipeline
   logic dv_vld_ff [0:DV];
   logic [45:0] dv_rem_ff [0:DV][0:2];
   logic [14:0] dv_q_ff [0:DV][0:2];
   logic [30:0] dv_len_ff [0:DV];
   sni_pkg::side_type dv_side_ff [0:DV];

   // stage j: signed normal, stage k: dot products
   logic j_vld_ff, k_vld_ff;
   logic signed [15:0] j_n_ff [0:2];
   logic signed [15:0] j_n_in [0:2];
   logic signed [15:0] k_n_ff [0:2];
   logic signed [48:0] k_p_ff [0:2];
   sni_pkg::side_type j_side_ff;
   logic k_err_ff, k_zb_ff;
   logic signed [50:0] dot_in;
   sni_pkg::rsp_type out_data_in;

   always_comb begin
      b_side_in     = '0;
      b_side_in.err = a_err_ff;
      b_side_in.dx  = a_d_ff[0];
      b_side_in.dy  = a_d_ff[1];
      b_side_in.dz  = a_d_ff[2];

      d_side_in = c_side_ff;
      for (int i = 0; i < 3; i++) begin
         d_side_in.neg[i] = c_b_ff[i] < 0;
      end
      d_side_in.zb = !c_side_ff.err && (c_b_ff[0] == 0) && (c_b_ff[1] == 0)
                     && (c_b_ff[2] == 0);

      e_m_in = d_mag_ff[0];
      if (d_mag_ff[1] > e_m_in) e_m_in = d_mag_ff[1];
      if (d_mag_ff[2] > e_m_in) e_m_in = d_mag_ff[2];

      for (int i = 0; i < 3; i++) begin
         if (f_pos_ff > 6'(sni_pkg::NORM_MSB)) begin
            g_mag_in[i] = 30'(f_mag_ff[i] >> (f_pos_ff - 6'(sni_pkg::NORM_MSB)));
         end else begin
            g_mag_in[i] = 30'(f_mag_ff[i] << (6'(sni_pkg::NORM_MSB) - f_pos_ff));
         end
      end

      for (int i = 0; i < 3; i++) begin
         if (dv_side_ff[DV].err || dv_side_ff[DV].zb) begin
            j_n_in[i] = '0;
         end else if (dv_side_ff[DV].neg[i]) begin
            j_n_in[i] = -$signed({1'b0, dv_q_ff[DV][i]});
         end else begin
            j_n_in[i] = $signed({1'b0, dv_q_ff[DV][i]});
         end
      end

      dot_in = 51'(k_p_ff[0]) + 51'(k_p_ff[1]) + 51'(k_p_ff[2]);
      out_data_in.index_error = k_err_ff;
      out_data_in.zero_blend  = k_zb_ff;
      if (dot_in < 0) begin
         out_data_in.norm_x = -k_n_ff[0];
         out_data_in.norm_y = -k_n_ff[1];
         out_data_in.norm_z = -k_n_ff[2];
      end else begin
         out_data_in.norm_x = k_n_ff[0];
         out_data_in.norm_y = k_n_ff[1];
         out_data_in.norm_z = k_n_ff[2];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff   <= 1'b0;
         b_vld_ff   <= 1'b0;
         c_vld_ff   <= 1'b0;
         d_vld_ff   <= 1'b0;
         e_vld_ff   <= 1'b0;
         f_vld_ff   <= 1'b0;
         g_vld_ff   <= 1'b0;
         h_vld_ff   <= 1'b0;
         sq_vld_ff[0] <= 1'b0;
         dv_vld_ff[0] <= 1'b0;
         j_vld_ff   <= 1'b0;
         k_vld_ff   <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         a_vld_ff   <= accept && (req_data.func == sni_pkg::FUNC_SHADE);
         b_vld_ff   <= a_vld_ff;
         c_vld_ff   <= b_vld_ff;
         d_vld_ff   <= c_vld_ff;
         e_vld_ff   <= d_vld_ff;
         f_vld_ff   <= e_vld_ff;
         g_vld_ff   <= f_vld_ff;
         h_vld_ff   <= g_vld_ff;
         sq_vld_ff[0] <= h_vld_ff;
         dv_vld_ff[0] <= sq_vld_ff[SQ];
         j_vld_ff   <= dv_vld_ff[DV];
         k_vld_ff   <= j_vld_ff;
         out_vld_ff <= k_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         a_err_ff <= a_err_in;
         a_w_ff[0] <= $signed(sni_pkg::ONE_Q16 - {2'b00, req_data.weight_u}
                              - {2'b00, req_data.weight_v});
         a_w_ff[1] <= $signed({2'b00, req_data.weight_u});
         a_w_ff[2] <= $signed({2'b00, req_data.weight_v});
         a_d_ff[0] <= 33'(req_data.eye_x) - 33'(req_data.vec_x);
         a_d_ff[1] <= 33'(req_data.eye_y) - 33'(req_data.vec_y);
         a_d_ff[2] <= 33'(req_data.eye_z) - 33'(req_data.vec_z);

         for (int i = 0; i < 3; i++) begin
            for (int c = 0; c < 3; c++) begin
               b_p_ff[i][c] <= $signed(rd_data[c][47-16*i -: 16]) * a_w_ff[c];
            end
         end
         b_side_ff <= b_side_in;

         for (int i = 0; i < 3; i++) begin
            c_b_ff[i] <= 37'(b_p_ff[i][0]) + 37'(b_p_ff[i][1]) + 37'(b_p_ff[i][2]);
         end
         c_side_ff <= b_side_ff;

         for (int i = 0; i < 3; i++) begin
            d_mag_ff[i] <= (c_b_ff[i] < 0) ? 36'(-c_b_ff[i]) : 36'(c_b_ff[i]);
         end
         d_side_ff <= d_side_in;

         e_mag_ff  <= d_mag_ff;
         e_m_ff    <= e_m_in;
         e_side_ff <= d_side_ff;

         f_mag_ff  <= e_mag_ff;
         f_pos_ff  <= lead_one(e_m_ff);
         f_side_ff <= e_side_ff;

         g_mag_ff  <= g_mag_in;
         g_side_ff <= f_side_ff;

         for (int i = 0; i < 3; i++) begin
            h_sq_ff[i] <= 60'(g_mag_ff[i]) * 60'(g_mag_ff[i]);
         end
         h_mag_ff  <= g_mag_ff;
         h_side_ff <= g_side_ff;

         sq_x_ff[0]    <= 62'(h_sq_ff[0]) + 62'(h_sq_ff[1]) + 62'(h_sq_ff[2]);
         sq_rem_ff[0]  <= '0;
         sq_root_ff[0] <= '0;
         sq_mag_ff[0]  <= h_mag_ff;
         sq_side_ff[0] <= h_side_ff;

         for (int i = 0; i < 3; i++) begin
            dv_rem_ff[0][i] <= {2'b00, sq_mag_ff[SQ][i], 14'b0}
                               + 46'(sq_root_ff[SQ] >> 1);
            dv_q_ff[0][i]   <= '0;
         end
         dv_len_ff[0]  <= sq_root_ff[SQ];
         dv_side_ff[0] <= sq_side_ff[SQ];

         j_n_ff    <= j_n_in;
         j_side_ff <= dv_side_ff[DV];

         k_n_ff[0] <= j_n_ff[0];
         k_n_ff[1] <= j_n_ff[1];
         k_n_ff[2] <= j_n_ff[2];
         k_p_ff[0] <= j_n_ff[0] * j_side_ff.dx;
         k_p_ff[1] <= j_n_ff[1] * j_side_ff.dy;
         k_p_ff[2] <= j_n_ff[2] * j_side_ff.dz;
         k_err_ff  <= j_side_ff.err;
         k_zb_ff   <= j_side_ff.zb;

         out_data_ff <= out_data_in;
      end
   end

   for (genvar s = 0; s < SQ; s++) begin : g_sqrt
      logic [34:0] shifted_rem, trial;
      logic take;

      always_comb begin
         shifted_rem = {sq_rem_ff[s][32:0], sq_x_ff[s][61:60]};
         trial       = {2'b00, sq_root_ff[s], 2'b01};
         take        = shifted_rem >= trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sq_vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            sq_vld_ff[s+1] <= sq_vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            sq_x_ff[s+1]    <= {sq_x_ff[s][59:0], 2'b00};
            sq_rem_ff[s+1]  <= take ? (shifted_rem - trial) : shifted_rem;
            sq_root_ff[s+1] <= {sq_root_ff[s][29:0], take};
            sq_mag_ff[s+1]  <= sq_mag_ff[s];
            sq_side_ff[s+1] <= sq_side_ff[s];
         end
      end
   end

   for (genvar s = 0; s < DV; s++) begin : g_div
      localparam int K = DV - 1 - s;
      logic [45:0] divisor;
      logic [2:0] take;

      always_comb begin
         divisor = 46'(dv_len_ff[s]) << K;
         for (int i = 0; i < 3; i++) begin
            take[i] = dv_rem_ff[s][i] >= divisor;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_vld_ff[s+1] <= 1'b0;
         end else if (adv) begin
            dv_vld_ff[s+1] <= dv_vld_ff[s];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int i = 0; i < 3; i++) begin
               dv_rem_ff[s+1][i] <= take[i] ? (dv_rem_ff[s][i] - divisor) : dv_rem_ff[s][i];
               dv_q_ff[s+1][i]   <= dv_q_ff[s][i] | (15'(take[i]) << K);
            end
            dv_len_ff[s+1]  <= dv_len_ff[s];
            dv_side_ff[s+1] <= dv_side_ff[s];
         end
      end
   end

endmodule
